### rtl/core/nrsp_pkg.sv
package nrsp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_TYPELEN = 4'd1,
    PH_PAYLEN  = 4'd2,
    PH_TYPE    = 4'd3,
    PH_IDLEN   = 4'd4,
    PH_ID      = 4'd5,
    PH_LANGLEN = 4'd6,
    PH_LANG    = 4'd7,
    PH_PAYLOAD = 4'd8,
    PH_DONE    = 4'd9
  } phase_t;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_UNDERFLOW = 2'd1;
  localparam logic [1:0] ERR_TRUNC     = 2'd2;

  localparam logic [2:0] TNF_WELL_KNOWN = 3'd1;
  localparam logic [7:0] TEXT_TYPE_CHAR = 8'h54;
  localparam logic [7:0] RECORD_MAX     = 8'hFF;

  localparam int HDR_ME = 6;
  localparam int HDR_SR = 4;
  localparam int HDR_IL = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [7:0]  echo_byte;
    logic [3:0]  field_kind;
    logic [7:0]  record_idx;
    logic        record_end;
    logic        message_end;
    logic [7:0]  header_flags;
    logic [7:0]  type_len_out;
    logic [7:0]  id_len_out;
    logic [7:0]  lang_len_out;
    logic [31:0] payload_len_out;
    logic [1:0]  error_code;
  } label_req_t;

endpackage

### rtl/core/ndef_record_stream_parser_core.sv
// Streaming NDEF record parser: one message byte per request in, one labeled
// byte per request out. Each output names the field the byte belongs to and
// carries the current record's header, lengths and (text-adjusted) payload
// length. Throughput is one byte per clock while label_stall is low. Each byte
// passes through an input register and then a result register, with the parse
// state updated as the byte is loaded into the result register. A byte flagged
// last_byte returns the parser to its reset state after it is labeled. Bytes
// after the record with ME set are labeled ignored until the next last_byte.
module ndef_record_stream_parser_core
  import nrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_req_t  byte_item,
  output logic       label_valid,
  input  logic       label_stall,
  output label_req_t label_item
);

  logic       held_valid;
  byte_req_t  held_item;
  logic       take;
  label_req_t result;

  nrsp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  nrsp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .held_item (held_item),
    .result    (result)
  );

  nrsp_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .held_valid  (held_valid),
    .result      (result),
    .take        (take),
    .label_valid (label_valid),
    .label_stall (label_stall),
    .label_item  (label_item)
  );

endmodule

### rtl/core/nrsp_in_stage.sv
module nrsp_in_stage
  import nrsp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_stall,
  input  byte_req_t byte_item,
  input  logic      take,
  output logic      held_valid,
  output byte_req_t held_item
);

  assign byte_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!byte_stall) begin
      held_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      held_item <= byte_item;
    end
  end

endmodule

### rtl/core/nrsp_step.sv
module nrsp_step
  import nrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_req_t  held_item,
  output label_req_t result
);

  typedef struct packed {
    phase_t      phase;
    logic        load;
    logic [31:0] bytes_left;
    logic        last;
  } adv_t;

  phase_t      phase, phase_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [1:0]  len_count, len_count_next;
  logic [7:0]  header, header_next;
  logic [7:0]  type_len, type_len_next;
  logic [7:0]  id_len, id_len_next;
  logic [7:0]  lang_len, lang_len_next;
  logic [31:0] payload_len, payload_len_next;
  logic [7:0]  first_type, first_type_next;
  logic [7:0]  record_count, record_count_next;
  logic        msg_done, msg_done_next;

  phase_t      kind;
  logic        adv_take;
  adv_t        adv;
  logic        rec_end;
  logic        msg_end;
  logic [1:0]  err;
  logic [31:0] dec;
  logic [31:0] lang_total;
  logic [7:0]  b;

  // skip absent or empty fields after the field that just completed
  function automatic adv_t advance(phase_t from, logic [7:0] hdr, logic [7:0] tl,
                                   logic [7:0] il, logic [7:0] ll, logic [31:0] pl,
                                   logic [7:0] ft);
    adv_t   r;
    phase_t nx;
    logic   text;
    logic   hit;
    r    = '0;
    r.phase = PH_DONE;
    hit  = 1'b0;
    text = (hdr[2:0] == TNF_WELL_KNOWN) && (tl == 8'd1) && (ft == TEXT_TYPE_CHAR);
    nx   = phase_t'(4'(from) + 4'd1);
    if (nx == PH_TYPE) begin
      if (tl != 8'd0) begin
        hit = 1'b1;
        r.phase = PH_TYPE;
        r.load = 1'b1;
        r.bytes_left = {24'd0, tl};
      end else begin
        nx = PH_IDLEN;
      end
    end
    if (!hit && nx == PH_IDLEN) begin
      if (hdr[HDR_IL]) begin
        hit = 1'b1;
        r.phase = PH_IDLEN;
      end else begin
        nx = PH_LANGLEN;
      end
    end
    if (!hit && nx == PH_ID) begin
      if (il != 8'd0) begin
        hit = 1'b1;
        r.phase = PH_ID;
        r.load = 1'b1;
        r.bytes_left = {24'd0, il};
      end else begin
        nx = PH_LANGLEN;
      end
    end
    if (!hit && nx == PH_LANGLEN) begin
      if (text) begin
        hit = 1'b1;
        r.phase = PH_LANGLEN;
      end else begin
        nx = PH_PAYLOAD;
      end
    end
    if (!hit && nx == PH_LANG) begin
      if (ll != 8'd0) begin
        hit = 1'b1;
        r.phase = PH_LANG;
        r.load = 1'b1;
        r.bytes_left = {24'd0, ll};
      end else begin
        nx = PH_PAYLOAD;
      end
    end
    if (!hit && nx == PH_PAYLOAD) begin
      if (pl != 32'd0) begin
        hit = 1'b1;
        r.phase = PH_PAYLOAD;
        r.load = 1'b1;
        r.bytes_left = pl;
      end
    end
    r.last = !hit;
    return r;
  endfunction

  assign b          = held_item.data_byte;
  assign dec        = (bytes_left != 32'd0) ? bytes_left - 32'd1 : 32'd0;
  assign lang_total = {24'd0, b} + 32'd1;

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    len_count_next    = len_count;
    header_next       = header;
    type_len_next     = type_len;
    id_len_next       = id_len;
    lang_len_next     = lang_len;
    payload_len_next  = payload_len;
    first_type_next   = first_type;
    record_count_next = record_count;
    msg_done_next     = msg_done;
    adv_take          = 1'b0;
    err               = ERR_NONE;

    kind = (msg_done || phase > PH_PAYLOAD) ? PH_DONE : phase;

    unique case (kind)
      PH_HEADER: begin
        header_next      = b;
        type_len_next    = 8'd0;
        id_len_next      = 8'd0;
        lang_len_next    = 8'd0;
        payload_len_next = 32'd0;
        first_type_next  = 8'd0;
        bytes_left_next  = 32'd0;
        len_count_next   = 2'd0;
        phase_next       = PH_TYPELEN;
      end
      PH_TYPELEN: begin
        type_len_next  = b;
        len_count_next = 2'd0;
        phase_next     = PH_PAYLEN;
      end
      PH_PAYLEN: begin
        if (header[HDR_SR]) begin
          payload_len_next = {24'd0, b};
          adv_take = 1'b1;
        end else begin
          payload_len_next = {payload_len[23:0], b};
          if (len_count == 2'd3) begin
            len_count_next = 2'd0;
            adv_take = 1'b1;
          end else begin
            len_count_next = len_count + 2'd1;
          end
        end
      end
      PH_TYPE: begin
        if (bytes_left == {24'd0, type_len}) begin
          first_type_next = b;
        end
        bytes_left_next = dec;
        adv_take = (dec == 32'd0);
      end
      PH_IDLEN: begin
        id_len_next = b;
        adv_take = 1'b1;
      end
      PH_LANGLEN: begin
        lang_len_next = b;
        if (payload_len >= lang_total) begin
          payload_len_next = payload_len - lang_total;
        end else begin
          payload_len_next = 32'd0;
          err = ERR_UNDERFLOW;
        end
        adv_take = 1'b1;
      end
      PH_ID, PH_LANG, PH_PAYLOAD: begin
        bytes_left_next = dec;
        adv_take = (dec == 32'd0);
      end
      default: begin
      end
    endcase

    adv = advance(kind, header_next, type_len_next, id_len_next, lang_len_next,
                  payload_len_next, first_type_next);
    rec_end = adv_take && adv.last;
    if (adv_take) begin
      phase_next = adv.phase;
      if (adv.load) begin
        bytes_left_next = adv.bytes_left;
      end
    end

    msg_end = rec_end && header_next[HDR_ME];
    if (held_item.last_byte && kind != PH_DONE && !rec_end) begin
      err = ERR_TRUNC;
    end

    result.echo_byte       = b;
    result.field_kind      = 4'(kind);
    result.record_idx      = record_count;
    result.record_end      = rec_end;
    result.message_end     = msg_end;
    result.header_flags    = header_next;
    result.type_len_out    = type_len_next;
    result.id_len_out      = id_len_next;
    result.lang_len_out    = lang_len_next;
    result.payload_len_out = payload_len_next;
    result.error_code      = err;

    if (rec_end) begin
      if (msg_end) begin
        msg_done_next = 1'b1;
        phase_next    = PH_DONE;
      end else begin
        if (record_count != RECORD_MAX) begin
          record_count_next = record_count + 8'd1;
        end
        phase_next = PH_HEADER;
      end
    end

    if (held_item.last_byte) begin
      phase_next        = PH_HEADER;
      bytes_left_next   = 32'd0;
      len_count_next    = 2'd0;
      header_next       = 8'd0;
      type_len_next     = 8'd0;
      id_len_next       = 8'd0;
      lang_len_next     = 8'd0;
      payload_len_next  = 32'd0;
      first_type_next   = 8'd0;
      record_count_next = 8'd0;
      msg_done_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      bytes_left   <= 32'd0;
      len_count    <= 2'd0;
      header       <= 8'd0;
      type_len     <= 8'd0;
      id_len       <= 8'd0;
      lang_len     <= 8'd0;
      payload_len  <= 32'd0;
      first_type   <= 8'd0;
      record_count <= 8'd0;
      msg_done     <= 1'b0;
    end else if (take) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      len_count    <= len_count_next;
      header       <= header_next;
      type_len     <= type_len_next;
      id_len       <= id_len_next;
      lang_len     <= lang_len_next;
      payload_len  <= payload_len_next;
      first_type   <= first_type_next;
      record_count <= record_count_next;
      msg_done     <= msg_done_next;
    end
  end

endmodule

### rtl/core/nrsp_out_stage.sv
module nrsp_out_stage
  import nrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       held_valid,
  input  label_req_t result,
  output logic       take,
  output logic       label_valid,
  input  logic       label_stall,
  output label_req_t label_item
);

  logic open;

  assign open = !label_valid || !label_stall;
  assign take = held_valid && open;

  always_ff @(posedge clk) begin
    if (rst) begin
      label_valid <= 1'b0;
    end else if (open) begin
      label_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      label_item <= result;
    end
  end

endmodule

### rtl/core/nrsp_checker.sv
module nrsp_checker
  import nrsp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input byte_req_t  byte_item,
  input logic       label_valid,
  input logic       label_stall,
  input label_req_t label_item
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !label_valid && !byte_stall)
    else $error("pipeline not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    label_valid && label_stall |=> label_valid && $stable(label_item))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
    else $error("stalled request changed");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    label_valid && label_item.field_kind == 4'(PH_DONE)
    |-> !label_item.record_end && label_item.error_code == ERR_NONE)
    else $error("ignored byte flagged");

  a_underflow_kind: assert property (@(posedge clk) disable iff (rst)
    label_valid && label_item.error_code == ERR_UNDERFLOW
    |-> label_item.field_kind == 4'(PH_LANGLEN))
    else $error("underflow outside language length byte");

endmodule

bind ndef_record_stream_parser_core nrsp_checker u_nrsp_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .byte_item   (byte_item),
  .label_valid (label_valid),
  .label_stall (label_stall),
  .label_item  (label_item)
);
